// ===== src/lz78y_pkg.sv =====
// types, constants and helper functions for the lz78y next-bit predictor
package lz78y_pkg;

  localparam int MAX_CONTEXT = 16;
  localparam int COUNT_BITS  = 32;
  localparam int CFG_BITS    = 5;
  localparam int OUT_BITS    = 32;
  localparam int LEN_BITS    = $clog2(MAX_CONTEXT + 1);
  localparam int ROW_BITS    = MAX_CONTEXT;
  localparam int STORE_ROWS  = 1 << ROW_BITS;
  localparam int EXT_BITS    = 64;

  typedef logic [COUNT_BITS-1:0]   count_t;
  typedef logic [2*COUNT_BITS-1:0] row_data_t;
  typedef logic [ROW_BITS-1:0]     row_addr_t;
  typedef logic [MAX_CONTEXT-1:0]  context_t;
  typedef logic [LEN_BITS-1:0]     len_t;
  typedef logic [CFG_BITS-1:0]     cfg_t;

  localparam count_t   COUNT_MAX    = '1;
  localparam count_t   COUNT_ONE    = count_t'(1);
  localparam cfg_t     CFG_RESET    = cfg_t'(MAX_CONTEXT);
  localparam row_addr_t LAST_ROW    = '1;

  function automatic len_t eff_len(input cfg_t n);
    len_t r;
    if (n == '0) begin
      r = len_t'(1);
    end else if (n > cfg_t'(MAX_CONTEXT)) begin
      r = len_t'(MAX_CONTEXT);
    end else begin
      r = len_t'(n);
    end
    return r;
  endfunction

  function automatic context_t ctx_mask(input len_t n);
    context_t ones;
    ones = '1;
    return ~(ones << n);
  endfunction

  function automatic logic [OUT_BITS-1:0] clip_out(input count_t c);
    logic [EXT_BITS-1:0] x;
    x = EXT_BITS'(c);
    return (x > EXT_BITS'({OUT_BITS{1'b1}})) ? '1 : x[OUT_BITS-1:0];
  endfunction

endpackage

// ===== src/lz78y_binary_predictor.sv =====
// lz78y binary next-bit predictor with a counter store in block memory
//
//   channel   direction  beat                                        handshake
//   in        sink       noise_bit                                   in_valid / in_ready
//   out       source     predicted_bit has_prediction best_count     out_valid / out_ready
//                        correct
//   cfg       sink       context_len                                 cfg_valid / cfg_ready
//
// one beat per cycle sustained; a result passes a read stage, then an update stage (update
// and write back of one counter row), into the output register; a row written in the cycle
// of the next read is forwarded from a bypass register
// after reset and after each cfg beat a clearing pass zeroes all 65536 rows of the counter
// store, one row per cycle, with in_ready low
// in stalls while the update stage holds a result that the output register cannot take,
// and while a cfg beat waits
module lz78y_binary_predictor
  import lz78y_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                noise_bit,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                predicted_bit,
  output logic                has_prediction,
  output logic [OUT_BITS-1:0] best_count,
  output logic                correct,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_BITS-1:0] context_len
);

  row_data_t store_mem [STORE_ROWS];

  cfg_t      ctx_len;
  context_t  ctx;
  len_t      fill_count;
  logic      clr_active;
  row_addr_t clr_addr;

  logic      s1_valid;
  logic      s1_bit;
  row_addr_t s1_row;
  row_data_t rdata;
  logic      fwd_valid;
  row_addr_t fwd_row;
  row_data_t fwd_data;

  len_t      len;
  context_t  ctx_next;
  logic      in_accept;
  logic      cfg_accept;
  logic      filling;
  logic      issue;
  logic      s1_adv;
  logic      s1_write;

  row_data_t row_data;
  count_t    c0;
  count_t    c1;
  count_t    best;
  count_t    actual;
  count_t    new_count;
  logic      pred;
  logic      has;
  row_data_t wdata;

  logic      mem_we;
  row_addr_t mem_waddr;
  row_data_t mem_wdata;

  assign len        = eff_len(ctx_len);
  assign ctx_next   = ({ctx[MAX_CONTEXT-2:0], noise_bit}) & ctx_mask(len);
  assign s1_adv     = !out_valid || out_ready;
  assign in_ready   = !clr_active && !cfg_valid && (!s1_valid || s1_adv);
  assign cfg_ready  = !s1_valid;
  assign in_accept  = in_valid && in_ready;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign filling    = fill_count < len;
  assign issue      = in_accept && !filling;
  assign s1_write   = s1_valid && s1_adv;

  // update stage
  always_comb begin
    row_data  = (fwd_valid && fwd_row == s1_row) ? fwd_data : rdata;
    c0        = row_data[COUNT_BITS-1:0];
    c1        = row_data[2*COUNT_BITS-1:COUNT_BITS];
    pred      = !(c0 > c1);
    best      = pred ? c1 : c0;
    has       = best != '0;
    actual    = s1_bit ? c1 : c0;
    if (!has) begin
      new_count = COUNT_ONE;
    end else if (actual == COUNT_MAX) begin
      new_count = actual;
    end else begin
      new_count = actual + COUNT_ONE;
    end
    wdata = s1_bit ? {new_count, c0} : {c1, new_count};
  end

  always_comb begin
    if (clr_active) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_write;
      mem_waddr = s1_row;
      mem_wdata = wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rdata <= store_mem[ctx[ROW_BITS-1:0]];
    end
  end

  // bypass for the row written at the edge of the next read
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (issue) begin
      fwd_valid <= s1_write;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      fwd_row  <= s1_row;
      fwd_data <= wdata;
      s1_row   <= ctx[ROW_BITS-1:0];
      s1_bit   <= noise_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx_len    <= CFG_RESET;
      ctx        <= '0;
      fill_count <= '0;
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (cfg_accept) begin
      ctx_len    <= context_len;
      ctx        <= '0;
      fill_count <= '0;
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else begin
      if (clr_active) begin
        clr_addr <= clr_addr + row_addr_t'(1);
        if (clr_addr == LAST_ROW) begin
          clr_active <= 1'b0;
        end
      end
      if (in_accept) begin
        ctx <= ctx_next;
        if (filling) begin
          fill_count <= fill_count + len_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (issue) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_write) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_write) begin
      predicted_bit  <= has && pred;
      has_prediction <= has;
      best_count     <= clip_out(best);
      correct        <= has && (pred == s1_bit);
    end
  end

endmodule

// ===== src/lz78y_checker.sv =====
// port checks for the lz78y predictor, bound to the top level
module lz78y_checker
  import lz78y_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                predicted_bit,
  input logic                has_prediction,
  input logic [OUT_BITS-1:0] best_count,
  input logic                correct,
  input logic                cfg_valid,
  input logic                cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(best_count) && $stable(predicted_bit))
    else $error("result beat changed while stalled");

  a_no_pred: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_prediction |-> !predicted_bit && best_count == '0 && !correct)
    else $error("empty prediction carries data");

  a_pred_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_prediction |-> best_count != '0)
    else $error("prediction with zero count");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("input taken during clearing pass");

  a_clear_after_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input taken after cfg beat before clearing");

endmodule

bind lz78y_binary_predictor lz78y_checker u_lz78y_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .predicted_bit  (predicted_bit),
  .has_prediction (has_prediction),
  .best_count     (best_count),
  .correct        (correct),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready)
);
